### rtl/irpd_pkg.sv
`timescale 1ns / 1ps

package irpd_pkg;

   localparam int unsigned TIME_W = 16;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_OUT_W = 6;
   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned FRAME_BITS_DEFAULT = 32;

   localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MARK_MIN = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MARK_MAX = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPACE_MIN = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SPACE_MAX = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_GAP_TIMEOUT = 3'd7;

   localparam logic [TIME_W-1:0] LEADER_MIN_RESET = 16'd4000;
   localparam logic [TIME_W-1:0] LEADER_MAX_RESET = 16'd5000;
   localparam logic [TIME_W-1:0] MARK_MIN_RESET = 16'd400;
   localparam logic [TIME_W-1:0] MARK_MAX_RESET = 16'd700;
   localparam logic [TIME_W-1:0] SPACE_MIN_RESET = 16'd400;
   localparam logic [TIME_W-1:0] SPACE_MAX_RESET = 16'd1800;
   localparam logic [TIME_W-1:0] ONE_THRESHOLD_RESET = 16'd1000;
   localparam logic [TIME_W-1:0] GAP_TIMEOUT_RESET = 16'd5000;

   typedef struct packed {
      logic [TIME_W-1:0] leader_min_us;
      logic [TIME_W-1:0] leader_max_us;
      logic [TIME_W-1:0] mark_min_us;
      logic [TIME_W-1:0] mark_max_us;
      logic [TIME_W-1:0] space_min_us;
      logic [TIME_W-1:0] space_max_us;
      logic [TIME_W-1:0] one_threshold_us;
      logic [TIME_W-1:0] gap_timeout_us;
   } cfg_type;

   typedef struct packed {
      logic                 frame_done;
      logic [WORD_W-1:0]    frame_word;
      logic                 decode_error;
      logic [CNT_OUT_W-1:0] bits_received;
   } result_type;

endpackage

### rtl/irpd_csr.sv
`timescale 1ns / 1ps

module irpd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [irpd_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [irpd_pkg::TIME_W-1:0]       csr_wdata,
   output irpd_pkg::cfg_type                 cfg
);
   import irpd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min_us <= LEADER_MIN_RESET;
         cfg_ff.leader_max_us <= LEADER_MAX_RESET;
         cfg_ff.mark_min_us <= MARK_MIN_RESET;
         cfg_ff.mark_max_us <= MARK_MAX_RESET;
         cfg_ff.space_min_us <= SPACE_MIN_RESET;
         cfg_ff.space_max_us <= SPACE_MAX_RESET;
         cfg_ff.one_threshold_us <= ONE_THRESHOLD_RESET;
         cfg_ff.gap_timeout_us <= GAP_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEADER_MIN: cfg_ff.leader_min_us <= csr_wdata;
            REG_LEADER_MAX: cfg_ff.leader_max_us <= csr_wdata;
            REG_MARK_MIN: cfg_ff.mark_min_us <= csr_wdata;
            REG_MARK_MAX: cfg_ff.mark_max_us <= csr_wdata;
            REG_SPACE_MIN: cfg_ff.space_min_us <= csr_wdata;
            REG_SPACE_MAX: cfg_ff.space_max_us <= csr_wdata;
            REG_ONE_THRESHOLD: cfg_ff.one_threshold_us <= csr_wdata;
            REG_GAP_TIMEOUT: cfg_ff.gap_timeout_us <= csr_wdata;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/irpd_core.sv
`timescale 1ns / 1ps

module irpd_core #(
   parameter int unsigned FRAME_BITS = irpd_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  irpd_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [irpd_pkg::TIME_W-1:0] req_interval_us,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output irpd_pkg::result_type        rsp
);
   import irpd_pkg::*;

   localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD_MARK,
      PH_LEAD_SPACE,
      PH_BIT_MARK,
      PH_BIT_SPACE,
      PH_DONE
   } phase_type;

   logic              in_valid_ff;
   logic [TIME_W-1:0] in_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   phase_type         phase_ff, phase_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   result_type        out_in;
   logic              advance;
   logic              gap, leader_ok, mark_ok, space_ok, err;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign gap = in_ff >= cfg.gap_timeout_us;
   assign leader_ok = (in_ff >= cfg.leader_min_us) && (in_ff <= cfg.leader_max_us);
   assign mark_ok = (in_ff >= cfg.mark_min_us) && (in_ff <= cfg.mark_max_us);
   assign space_ok = (in_ff >= cfg.space_min_us) && (in_ff <= cfg.space_max_us);

   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      cnt_in = cnt_ff;
      err = 1'b0;
      out_in.frame_done = 1'b0;
      out_in.frame_word = '0;
      if (gap || phase_ff == PH_IDLE) begin
         phase_in = PH_LEAD_MARK;
         shift_in = '0;
         cnt_in = '0;
      end else begin
         unique case (phase_ff)
            PH_LEAD_MARK: begin
               if (!leader_ok) err = 1'b1;
               else phase_in = PH_LEAD_SPACE;
            end
            PH_LEAD_SPACE: begin
               if (!leader_ok) err = 1'b1;
               else phase_in = PH_BIT_MARK;
            end
            PH_BIT_MARK: begin
               if (!mark_ok) err = 1'b1;
               else phase_in = PH_BIT_SPACE;
            end
            PH_BIT_SPACE: begin
               if (!space_ok) begin
                  err = 1'b1;
               end else begin
                  shift_in = {shift_ff[WORD_W-2:0], in_ff > cfg.one_threshold_us};
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff >= LAST_BIT) begin
                     out_in.frame_done = 1'b1;
                     out_in.frame_word = shift_in;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_BIT_MARK;
                  end
               end
            end
            default: phase_in = PH_DONE;
         endcase
         if (err) begin
            phase_in = PH_IDLE;
            cnt_in = '0;
         end
      end
      cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_in};
      out_in.decode_error = err;
      out_in.bits_received = cnt_ext[CNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_ff <= req_interval_us;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            cnt_ff <= cnt_in;
            out_ff <= out_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;

endmodule

### rtl/ir_pulse_distance_decoder.sv
`timescale 1ns / 1ps
// channel  | handshake                     | payload
// req      | req_valid / req_ready         | req_interval_us[15:0]
// rsp      | rsp_valid / rsp_ready         | rsp_frame_done, rsp_frame_word[31:0],
//          |                               | rsp_decode_error, rsp_bits_received[5:0]
// csr      | csr_we (no wait, no readback) | csr_index[2:0], csr_wdata[15:0]
//
// One item per cycle sustained while rsp_ready holds high; each item is captured
// in the input register and then decoded into the result register.
// rsp_valid rises once the item has moved from the input register into the
// result register.
// Synchronous reset restores register defaults and returns the decoder to idle.
// A stalled result holds the input register; req_ready drops only when both
// stages are full and rsp_ready is low.

module ir_pulse_distance_decoder #(
   parameter int unsigned FRAME_BITS = irpd_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [irpd_pkg::TIME_W-1:0]    req_interval_us,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_frame_done,
   output logic [irpd_pkg::WORD_W-1:0]    rsp_frame_word,
   output logic                           rsp_decode_error,
   output logic [irpd_pkg::CNT_OUT_W-1:0] rsp_bits_received,
   input  logic                           csr_we,
   input  logic [irpd_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [irpd_pkg::TIME_W-1:0]    csr_wdata
);
   import irpd_pkg::*;

   localparam logic [CNT_OUT_W-1:0] FRAME_CNT = CNT_OUT_W'(FRAME_BITS);

   cfg_type    cfg;
   result_type rsp;

   irpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irpd_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_interval_us (req_interval_us),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp)
   );

   assign rsp_frame_done = rsp.frame_done;
   assign rsp_frame_word = rsp.frame_word;
   assign rsp_decode_error = rsp.decode_error;
   assign rsp_bits_received = rsp.bits_received;

   a_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_bits_received == FRAME_CNT)
      else $error("frame completed with wrong bit count");

   a_done_xor_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_done && rsp_decode_error))
      else $error("frame completion and error on the same item");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_frame_word == '0)
      else $error("word set without frame completion");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decode_error |-> rsp_bits_received == '0)
      else $error("bit count kept after error");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import irpd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_PCT = 28;

   localparam cfg_type TIMING_DEFAULT = {
      LEADER_MIN_RESET, LEADER_MAX_RESET, MARK_MIN_RESET, MARK_MAX_RESET,
      SPACE_MIN_RESET, SPACE_MAX_RESET, ONE_THRESHOLD_RESET, GAP_TIMEOUT_RESET
   };

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK, PH_BIT_SPACE, PH_DONE
   } phase_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_interval_us = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_frame_done;
   logic [WORD_W-1:0]    rsp_frame_word;
   logic                 rsp_decode_error;
   logic [CNT_OUT_W-1:0] rsp_bits_received;
   logic                 csr_we = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   // decoder model state
   cfg_type           timing = TIMING_DEFAULT;
   phase_type         rx_phase = PH_IDLE;
   logic [WORD_W-1:0] rx_word = '0;
   int                rx_bits = 0;

   logic [TIME_W-1:0] pending_intervals[$];
   result_type        expected_results[$];
   logic              req_taken = 1'b0;
   int                queued_items = 0;
   int                accepted_items = 0;
   int                failures = 0;
   int                cycle_count = 0;
   int                req_idle_pct = IDLE_PCT;
   int                rsp_stall_pct = IDLE_PCT;

   ir_pulse_distance_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_interval_us(req_interval_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_done(rsp_frame_done),
      .rsp_frame_word(rsp_frame_word),
      .rsp_decode_error(rsp_decode_error),
      .rsp_bits_received(rsp_bits_received),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit in_window(input logic [TIME_W-1:0] t, lo, hi);
      return t >= lo && t <= hi;
   endfunction

   task automatic decode_edge(input logic [TIME_W-1:0] t);
      result_type r;
      r = '0;
      if (t >= timing.gap_timeout_us || rx_phase == PH_IDLE) begin
         rx_phase = PH_LEAD_MARK;
         rx_word = '0;
         rx_bits = 0;
      end else begin
         case (rx_phase)
            PH_LEAD_MARK, PH_LEAD_SPACE: begin
               if (!in_window(t, timing.leader_min_us, timing.leader_max_us))
                  r.decode_error = 1'b1;
               else
                  rx_phase = (rx_phase == PH_LEAD_MARK) ? PH_LEAD_SPACE : PH_BIT_MARK;
            end
            PH_BIT_MARK: begin
               if (!in_window(t, timing.mark_min_us, timing.mark_max_us))
                  r.decode_error = 1'b1;
               else
                  rx_phase = PH_BIT_SPACE;
            end
            PH_BIT_SPACE: begin
               if (!in_window(t, timing.space_min_us, timing.space_max_us)) begin
                  r.decode_error = 1'b1;
               end else begin
                  rx_word = {rx_word[WORD_W-2:0], t > timing.one_threshold_us};
                  rx_bits++;
                  if (rx_bits >= FRAME_BITS_DEFAULT) begin
                     r.frame_done = 1'b1;
                     r.frame_word = rx_word;
                     rx_phase = PH_DONE;
                  end else begin
                     rx_phase = PH_BIT_MARK;
                  end
               end
            end
            default: rx_phase = PH_DONE;
         endcase
         if (r.decode_error) begin
            rx_phase = PH_IDLE;
            rx_bits = 0;
         end
      end
      r.bits_received = rx_bits[CNT_OUT_W-1:0];
      expected_results.push_back(r);
   endtask

   task automatic check_field(input string field, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         timing = TIMING_DEFAULT;
         rx_phase = PH_IDLE;
         rx_word = '0;
         rx_bits = 0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            decode_edge(req_interval_us);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item, done %0b word %h error %0b bits %0d",
                        $time, rsp_frame_done, rsp_frame_word, rsp_decode_error,
                        rsp_bits_received);
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("frame_done", want.frame_done, rsp_frame_done);
               check_field("frame_word", want.frame_word, rsp_frame_word);
               check_field("decode_error", want.decode_error, rsp_decode_error);
               check_field("bits_received", want.bits_received, rsp_bits_received);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= $urandom_range(99) >= rsp_stall_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_intervals.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_valid <= 1'b1;
            req_interval_us <= pending_intervals.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] pick(input int lo, input int hi);
      if (lo > hi)
         return TIME_W'($urandom_range(65535, 0));
      return TIME_W'($urandom_range(hi, lo));
   endfunction

   task automatic queue_item(input logic [TIME_W-1:0] t);
      pending_intervals.push_back(t);
      queued_items++;
   endtask

   task automatic queue_noise(input int count);
      repeat (count) begin
         if ($urandom_range(1))
            queue_item(pick(0, 65535));
         else
            queue_item(pick(0, 2 * int'(timing.gap_timeout_us)));
      end
   endtask

   // opening (mostly gap) edge, leader, 32 mark/space pairs, then a few edges that the done phase ignores
   task automatic queue_frame(input bit broken);
      logic [TIME_W-1:0] edges[$];
      int lo, hi, thr, k;
      if ($urandom_range(3) == 0)
         edges.push_back(pick(0, 65535));
      else
         edges.push_back(pick(timing.gap_timeout_us, 65535));
      edges.push_back(pick(timing.leader_min_us, timing.leader_max_us));
      edges.push_back(pick(timing.leader_min_us, timing.leader_max_us));
      for (int b = 0; b < FRAME_BITS_DEFAULT; b++) begin
         edges.push_back(pick(timing.mark_min_us, timing.mark_max_us));
         lo = timing.space_min_us;
         hi = timing.space_max_us;
         thr = timing.one_threshold_us;
         if ($urandom_range(1)) begin
            if (thr + 1 > lo)
               lo = thr + 1;
         end else if (thr < hi) begin
            hi = thr;
         end
         if (lo > hi) begin
            lo = timing.space_min_us;
            hi = timing.space_max_us;
         end
         edges.push_back(pick(lo, hi));
      end
      repeat ($urandom_range(3))
         edges.push_back(pick(0, int'(timing.gap_timeout_us) - 1));
      if (broken) begin
         k = $urandom_range(edges.size() - 1, 1);
         case ($urandom_range(2))
            0: edges[k] = pick(0, 65535);
            1: edges[k] = edges[k] + TIME_W'($urandom_range(400, 1));
            default: edges[k] = edges[k] - TIME_W'($urandom_range(400, 1));
         endcase
      end
      foreach (edges[i])
         queue_item(edges[i]);
   endtask

   task automatic wait_idle();
      while (accepted_items != queued_items || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      write_reg(REG_LEADER_MIN, c.leader_min_us);
      write_reg(REG_LEADER_MAX, c.leader_max_us);
      write_reg(REG_MARK_MIN, c.mark_min_us);
      write_reg(REG_MARK_MAX, c.mark_max_us);
      write_reg(REG_SPACE_MIN, c.space_min_us);
      write_reg(REG_SPACE_MAX, c.space_max_us);
      write_reg(REG_ONE_THRESHOLD, c.one_threshold_us);
      write_reg(REG_GAP_TIMEOUT, c.gap_timeout_us);
      csr_we <= 1'b0;
      timing = c;
   endtask

   function automatic cfg_type random_timing();
      cfg_type c;
      c.leader_min_us = TIME_W'($urandom_range(6000, 1000));
      c.leader_max_us = c.leader_min_us + TIME_W'($urandom_range(3000, 0));
      c.mark_min_us = TIME_W'($urandom_range(800, 0));
      c.mark_max_us = c.mark_min_us + TIME_W'($urandom_range(600, 0));
      c.space_min_us = TIME_W'($urandom_range(800, 0));
      c.space_max_us = c.space_min_us + TIME_W'($urandom_range(2500, 0));
      case ($urandom_range(3))
         0: c.one_threshold_us = '0;
         1: c.one_threshold_us = '1;
         default: c.one_threshold_us = pick(c.space_min_us, c.space_max_us);
      endcase
      c.gap_timeout_us = c.leader_max_us + TIME_W'($urandom_range(20000, 1));
      return c;
   endfunction

   initial begin
      cfg_type c;
      logic [TIME_W-1:0] directed[$];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window edges, gap restarts and errors in each phase at reset timing
      directed = '{16'd0, 16'd3999, 16'd65535, 16'd5001, 16'd4000, 16'd4999, 16'd399,
                   16'd0, 16'd4999, 16'd4000, 16'd700, 16'd1801, 16'd1, 16'd4000,
                   16'd4000, 16'd400, 16'd1000, 16'd701, 16'd65534, 16'd5000, 16'd5001,
                   16'd4000, 16'd400, 16'd1001, 16'd5000};
      foreach (directed[i])
         queue_item(directed[i]);
      wait_idle();

      repeat (5) queue_frame($urandom_range(3) == 0);
      queue_noise(30);
      wait_idle();

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (3) queue_frame($urandom_range(3) == 0);
      wait_idle();
      req_idle_pct = IDLE_PCT;
      rsp_stall_pct = IDLE_PCT;

      apply_config('0);
      queue_noise(40);
      queue_frame(1'b0);
      wait_idle();

      apply_config('1);
      queue_noise(30);
      queue_frame(1'b0);
      wait_idle();

      // inverted windows
      c = TIMING_DEFAULT;
      c.leader_min_us = LEADER_MAX_RESET;
      c.leader_max_us = LEADER_MIN_RESET;
      apply_config(c);
      queue_frame(1'b0);
      queue_noise(10);
      wait_idle();

      c = TIMING_DEFAULT;
      c.mark_min_us = MARK_MAX_RESET;
      c.mark_max_us = MARK_MIN_RESET;
      apply_config(c);
      queue_frame(1'b0);
      wait_idle();

      c = TIMING_DEFAULT;
      c.space_min_us = SPACE_MAX_RESET;
      c.space_max_us = SPACE_MIN_RESET;
      apply_config(c);
      queue_frame(1'b0);
      wait_idle();

      repeat (2) begin
         apply_config(random_timing());
         repeat (2) queue_frame($urandom_range(3) == 0);
         queue_noise(15);
         wait_idle();
      end

      if (failures == 0 && expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
rtl/irpd_pkg.sv
rtl/irpd_csr.sv
rtl/irpd_core.sv
rtl/ir_pulse_distance_decoder.sv
tb/sv/testbench.sv
